### sv/tle_pkg.sv
// shared types, sizes and byte codes of the terminal line editor
`default_nettype none
package tle_pkg;

    // sizes
    localparam int LINE_BYTES    = 16;
    localparam int HISTORY_DEPTH = 4;
    localparam int LEN_W         = $clog2(LINE_BYTES);
    localparam int HIST_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

    // terminal byte codes
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_DOWN  = 8'h42;

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ECHO = 2'd0;
    localparam t_kind KIND_LINE = 2'd1;
    localparam t_kind KIND_END  = 2'd2;

    // editing commands passed from front to back
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_BS,
        OP_ENTER,
        OP_UP,
        OP_DOWN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

### sv/terminal_line_editor.sv
// terminal line editor with history: top level
// results: at most one per cycle, and none while the output is stalled
// a recall of n bytes over an m byte line emits three erase results per line byte, then n echoes,
//   all from the back sequencer
// a two-entry command queue lets bytes be taken while results are still draining
// reset: synchronous active low, clears edit length, escape phase and history count;
//   line and history stores are not cleared, only written entries are read
`default_nettype none
module terminal_line_editor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // received byte stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // last result of one received byte
);
    import tle_pkg::*;

    // command path from the classifier to the sequencer
    logic      push;
    t_cmd      push_cmd;
    logic      pop;
    t_cmd      head_cmd;
    t_q_status q_status;

    // front: escape decoding, drops bytes that carry no command
    tle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // queue decouples byte intake from result emission
    tle_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // back: edit line, history ring, result register
    tle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

### sv/tle_front.sv
// input side: escape decoding and command classification
`default_nettype none
module tle_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire  [7:0]               s_axis_tdata,   // [7:0] rx_byte
    input  wire  tle_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output tle_pkg::t_cmd            o_cmd
);
    import tle_pkg::*;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_CSI
    } t_esc_state;

    t_esc_state r_esc;
    logic       accept;

    assign s_axis_tready = !i_q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classification of the byte under the current escape phase
    always_comb begin
        o_push       = 1'b0;
        o_cmd.op     = OP_CHAR;
        o_cmd.data   = s_axis_tdata;
        case (r_esc)
            ESC_SEEN: begin
                o_push = 1'b0;
            end
            ESC_CSI: begin
                if (s_axis_tdata == BYTE_UP) begin
                    o_push   = accept;
                    o_cmd.op = OP_UP;
                end else if (s_axis_tdata == BYTE_DOWN) begin
                    o_push   = accept;
                    o_cmd.op = OP_DOWN;
                end
            end
            default: begin
                if (s_axis_tdata == BYTE_ESC) begin
                    o_push = 1'b0;
                end else if (s_axis_tdata == BYTE_CR || s_axis_tdata == BYTE_LF) begin
                    o_push   = accept;
                    o_cmd.op = OP_ENTER;
                end else if (s_axis_tdata == BYTE_BS || s_axis_tdata == BYTE_DEL) begin
                    o_push   = accept;
                    o_cmd.op = OP_BS;
                end else begin
                    o_push   = accept;
                    o_cmd.op = OP_CHAR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESC_IDLE;
        end else if (accept) begin
            case (r_esc)
                ESC_SEEN: begin
                    r_esc <= (s_axis_tdata == BYTE_LBRK) ? ESC_CSI : ESC_IDLE;
                end
                ESC_CSI: begin
                    r_esc <= ESC_IDLE;
                end
                default: begin
                    r_esc <= (s_axis_tdata == BYTE_ESC) ? ESC_SEEN : ESC_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/tle_cmdq.sv
// short command queue between front and back
`default_nettype none
module tle_cmdq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire tle_pkg::t_cmd  i_cmd,
    input  wire                 i_pop,
    output tle_pkg::t_cmd       o_head,
    output tle_pkg::t_q_status  o_status
);
    import tle_pkg::*;

    t_cmd                  r_slots [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_head         = r_slots[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("command pushed into a full queue");

endmodule
`default_nettype wire

### sv/tle_back.sv
// output side: edit line, history ring and result sequencer
`default_nettype none
module tle_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  tle_pkg::t_cmd      i_cmd,
    input  wire  tle_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [7:0]               m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]               m_axis_tuser,   // [1:0] out_kind
    output logic                     m_axis_tlast    // last
);
    import tle_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_BS,
        ST_ERASE,
        ST_RECALL,
        ST_CRLF,
        ST_LINE,
        ST_END
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic              n_out_valid;
    t_kind             r_out_kind;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [7:0]        r_line [LINE_BYTES];
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_fin_len;
    logic [LEN_W-1:0]  r_rc_len;
    logic [HIST_W-1:0] r_rc_slot;
    logic [LEN_W-1:0]  r_idx;
    logic [1:0]        r_phase;
    logic [7:0]        r_byte;

    logic [7:0]        r_hist_mem [HISTORY_DEPTH][LINE_BYTES];
    logic [LEN_W-1:0]  r_hist_len [HISTORY_DEPTH];
    logic [7:0]        r_rd_data;
    logic [HIST_W-1:0] r_wslot;
    logic [CNT_W-1:0]  r_count;
    logic [HIST_W-1:0] r_off;
    logic              r_active;

    logic              adv;
    logic [HIST_W-1:0] off_new;
    logic [HIST_W:0]   slot_sum;
    logic [HIST_W-1:0] slot_calc;
    logic              up_ok;
    logic [HIST_W-1:0] rd_slot;
    logic [LEN_W-1:0]  rd_idx;
    logic              hist_we;
    logic [7:0]        erase_byte;

    assign adv           = !r_out_valid || m_axis_tready;
    assign o_pop         = (r_state == ST_IDLE) && !i_q_status.empty;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign erase_byte    = (r_phase == 2'd1) ? BYTE_SPACE : BYTE_BS;

    // output valid: states that emit load a result whenever the register frees up
    always_comb begin
        case (r_state)
            ST_CHAR, ST_BS, ST_RECALL, ST_CRLF, ST_LINE, ST_END: begin
                n_out_valid = adv ? 1'b1 : r_out_valid;
            end
            ST_ERASE: begin
                n_out_valid = adv ? (r_len != '0) : r_out_valid;
            end
            default: begin
                n_out_valid = adv ? 1'b0 : r_out_valid;
            end
        endcase
    end

    // offset after this browse step and the ring slot it points at
    assign up_ok = (r_count != '0) &&
                   (!r_active || ((CNT_W'(r_off) + 1'b1) < r_count));
    always_comb begin
        if (i_cmd.op == OP_UP) begin
            off_new = r_active ? r_off + 1'b1 : '0;
        end else begin
            off_new = r_off - 1'b1;
        end
        slot_sum = {1'b0, r_wslot} + (HIST_W + 1)'(HISTORY_DEPTH - 1) - {1'b0, off_new};
        if (slot_sum >= (HIST_W + 1)'(HISTORY_DEPTH)) begin
            slot_calc = HIST_W'(slot_sum - (HIST_W + 1)'(HISTORY_DEPTH));
        end else begin
            slot_calc = HIST_W'(slot_sum);
        end
    end

    // history read address runs one step ahead of the recall index
    always_comb begin
        rd_slot = (r_state == ST_IDLE) ? slot_calc : r_rc_slot;
        if (r_state == ST_RECALL) begin
            rd_idx = adv ? r_idx + 1'b1 : r_idx;
        end else begin
            rd_idx = '0;
        end
    end

    assign hist_we = (r_state == ST_LINE) && adv;

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_wslot][r_idx] <= r_line[r_idx];
        end
        r_rd_data <= r_hist_mem[rd_slot][rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_wslot     <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_active    <= 1'b0;
            r_phase     <= '0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    r_phase <= '0;
                    r_idx   <= '0;
                    if (!i_q_status.empty) begin
                        case (i_cmd.op)
                            OP_CHAR: begin
                                if (r_len < LEN_W'(LINE_BYTES - 1)) begin
                                    r_line[r_len] <= i_cmd.data;
                                    r_len         <= r_len + 1'b1;
                                    r_byte        <= i_cmd.data;
                                    r_state       <= ST_CHAR;
                                end
                            end
                            OP_BS: begin
                                if (r_len != '0) begin
                                    r_len   <= r_len - 1'b1;
                                    r_state <= ST_BS;
                                end
                            end
                            OP_ENTER: begin
                                r_fin_len <= r_len;
                                r_len     <= '0;
                                r_state   <= ST_CRLF;
                            end
                            OP_UP: begin
                                if (up_ok) begin
                                    r_active  <= 1'b1;
                                    r_off     <= off_new;
                                    r_rc_slot <= slot_calc;
                                    r_rc_len  <= r_hist_len[slot_calc];
                                    r_state   <= ST_ERASE;
                                end
                            end
                            OP_DOWN: begin
                                if (r_active) begin
                                    if (r_off == '0) begin
                                        // past the newest line: erase only
                                        r_active <= 1'b0;
                                        r_rc_len <= '0;
                                    end else begin
                                        r_off     <= off_new;
                                        r_rc_slot <= slot_calc;
                                        r_rc_len  <= r_hist_len[slot_calc];
                                    end
                                    r_state <= ST_ERASE;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CHAR: begin
                    if (adv) begin
                        r_out_kind  <= KIND_ECHO;
                        r_out_byte  <= r_byte;
                        r_out_last  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_BS: begin
                    if (adv) begin
                        r_out_kind  <= KIND_ECHO;
                        r_out_byte  <= erase_byte;
                        r_out_last  <= (r_phase == 2'd2);
                        if (r_phase == 2'd2) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_phase <= r_phase + 1'b1;
                        end
                    end
                end
                ST_ERASE: begin
                    if (r_len == '0) begin
                        r_state <= (r_rc_len != '0) ? ST_RECALL : ST_IDLE;
                    end else if (adv) begin
                        r_out_kind  <= KIND_ECHO;
                        r_out_byte  <= erase_byte;
                        r_out_last  <= (r_phase == 2'd2) && (r_len == LEN_W'(1)) &&
                                       (r_rc_len == '0);
                        if (r_phase == 2'd2) begin
                            r_phase <= '0;
                            r_len   <= r_len - 1'b1;
                        end else begin
                            r_phase <= r_phase + 1'b1;
                        end
                    end
                end
                ST_RECALL: begin
                    if (adv) begin
                        r_out_kind    <= KIND_ECHO;
                        r_out_byte    <= r_rd_data;
                        r_out_last    <= (r_idx == r_rc_len - 1'b1);
                        r_line[r_idx] <= r_rd_data;
                        if (r_idx == r_rc_len - 1'b1) begin
                            r_len   <= r_rc_len;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_CRLF: begin
                    if (adv) begin
                        r_out_kind  <= KIND_ECHO;
                        r_out_byte  <= (r_phase == 2'd0) ? BYTE_CR : BYTE_LF;
                        r_out_last  <= (r_phase != 2'd0) && (r_fin_len == '0);
                        if (r_phase == 2'd0) begin
                            r_phase <= 2'd1;
                        end else begin
                            r_idx   <= '0;
                            r_state <= (r_fin_len != '0) ? ST_LINE : ST_IDLE;
                        end
                    end
                end
                ST_LINE: begin
                    if (adv) begin
                        r_out_kind  <= KIND_LINE;
                        r_out_byte  <= r_line[r_idx];
                        r_out_last  <= 1'b0;
                        if (r_idx == r_fin_len - 1'b1) begin
                            r_state <= ST_END;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_END: begin
                    if (adv) begin
                        r_out_kind          <= KIND_END;
                        r_out_byte          <= '0;
                        r_out_last          <= 1'b1;
                        r_hist_len[r_wslot] <= r_fin_len;
                        r_wslot             <= (r_wslot == HIST_W'(HISTORY_DEPTH - 1)) ?
                                               '0 : r_wslot + 1'b1;
                        if (r_count != CNT_W'(HISTORY_DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_active <= 1'b0;
                        r_off    <= '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> r_out_last)
        else $error("end marker not flagged as last");

    a_browse_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (CNT_W'(r_off) < r_count))
        else $error("browse offset beyond saved lines");

    a_end_stores_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && adv) |=> (r_state == ST_IDLE && r_count != '0 && !r_active))
        else $error("finished line not stored");

endmodule
`default_nettype wire

### dv/tle_result_checker.sv
// result checker for the terminal line editor: predicts results per received byte and compares
module tle_result_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // received byte channel as seen at the block input
    input  wire        i_rx_valid,
    input  wire        i_rx_ready,
    input  wire  [7:0] i_rx_byte,
    // result channel as seen at the block output
    input  wire        i_res_valid,
    input  wire        i_res_ready,
    input  wire  [7:0] i_res_byte,
    input  wire  [1:0] i_res_kind,
    input  wire        i_res_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_lines
);
    import tle_pkg::*;

    localparam int MAX_RESULTS = 60;
    localparam int SHOW_LIMIT  = 10;

    // escape parser states
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // editor state mirror
    logic [1:0]        seq_phase;
    logic [7:0]        edit_bytes [LINE_BYTES];
    logic [LEN_W-1:0]  line_len;
    logic [7:0]        hist_buf [HISTORY_DEPTH][LINE_BYTES];
    logic [LEN_W-1:0]  hist_len [HISTORY_DEPTH];
    logic [HIST_W-1:0] hist_wr;
    logic [CNT_W-1:0]  hist_cnt;
    logic [CNT_W-1:0]  browse_back;
    logic              browsing;

    t_result step_res [MAX_RESULTS];
    int      step_n;
    t_result expected_q [$];

    task automatic emit(input t_kind k, input logic [7:0] d);
        t_result r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        if (step_n < MAX_RESULTS) begin
            step_res[step_n] = r;
            step_n++;
        end
    endtask

    task automatic erase_line();
        while (line_len > 0) begin
            emit(KIND_ECHO, BYTE_BS);
            emit(KIND_ECHO, BYTE_SPACE);
            emit(KIND_ECHO, BYTE_BS);
            line_len--;
        end
    endtask

    task automatic recall_entry();
        int               slot;
        logic [LEN_W-1:0] n;
        slot = (int'(hist_wr) + HISTORY_DEPTH - 1 - int'(browse_back)) % HISTORY_DEPTH;
        n = hist_len[slot];
        erase_line();
        for (int i = 0; i < int'(n); i++) begin
            edit_bytes[i] = hist_buf[slot][i];
            emit(KIND_ECHO, edit_bytes[i]);
        end
        line_len = n;
    endtask

    // one received byte: update the mirror and queue what the block should emit
    task automatic apply_rx_byte(input logic [7:0] b);
        t_result r;
        step_n = 0;
        case (seq_phase)
            ESC_SEEN: begin
                seq_phase = (b == BYTE_LBRK) ? ESC_CSI : ESC_IDLE;
            end
            ESC_CSI: begin
                seq_phase = ESC_IDLE;
                if (b == BYTE_UP) begin
                    // older line, stays put at the oldest
                    if (hist_cnt != 0) begin
                        if (!browsing) begin
                            browsing    = 1'b1;
                            browse_back = '0;
                            recall_entry();
                        end else if (int'(browse_back) + 1 < int'(hist_cnt)) begin
                            browse_back++;
                            recall_entry();
                        end
                    end
                end else if (b == BYTE_DOWN && browsing) begin
                    if (browse_back == 0) begin
                        browsing = 1'b0;
                        erase_line();
                    end else begin
                        browse_back--;
                        recall_entry();
                    end
                end
            end
            default: begin
                seq_phase = ESC_IDLE;
                if (b == BYTE_ESC) begin
                    seq_phase = ESC_SEEN;
                end else if (b == BYTE_CR || b == BYTE_LF) begin
                    emit(KIND_ECHO, BYTE_CR);
                    emit(KIND_ECHO, BYTE_LF);
                    if (line_len != 0) begin
                        for (int i = 0; i < int'(line_len); i++) begin
                            emit(KIND_LINE, edit_bytes[i]);
                            hist_buf[hist_wr][i] = edit_bytes[i];
                        end
                        emit(KIND_END, 8'h00);
                        hist_len[hist_wr] = line_len;
                        hist_wr = HIST_W'((int'(hist_wr) + 1) % HISTORY_DEPTH);
                        if (int'(hist_cnt) < HISTORY_DEPTH)
                            hist_cnt++;
                        browsing    = 1'b0;
                        browse_back = '0;
                    end
                    line_len = '0;
                end else if (b == BYTE_BS || b == BYTE_DEL) begin
                    if (line_len > 0) begin
                        line_len--;
                        emit(KIND_ECHO, BYTE_BS);
                        emit(KIND_ECHO, BYTE_SPACE);
                        emit(KIND_ECHO, BYTE_BS);
                    end
                end else if (int'(line_len) < LINE_BYTES - 1) begin
                    edit_bytes[line_len] = b;
                    line_len++;
                    emit(KIND_ECHO, b);
                end
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            expected_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            seq_phase    = ESC_IDLE;
            line_len     = '0;
            hist_wr      = '0;
            hist_cnt     = '0;
            browse_back  = '0;
            browsing     = 1'b0;
            expected_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_lines      = 0;
        end else begin
            if (i_rx_valid && i_rx_ready)
                apply_rx_byte(i_rx_byte);
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= SHOW_LIMIT)
                        $display("unexpected result at %0t: kind %0d byte %02h last %0b",
                                 $time, i_res_kind, i_res_byte, i_res_last);
                end else begin
                    want = expected_q.pop_front();
                    o_checked++;
                    if (want.kind == KIND_END)
                        o_lines++;
                    if (want.kind !== i_res_kind || want.data !== i_res_byte
                            || want.last !== i_res_last) begin
                        o_fail_count++;
                        if (o_fail_count <= SHOW_LIMIT) begin
                            $display("mismatch at %0t: expected kind %0d byte %02h last %0b",
                                     $time, want.kind, want.data, want.last);
                            $display("    got kind %0d byte %02h last %0b",
                                     i_res_kind, i_res_byte, i_res_last);
                        end
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### dv/terminal_line_editor_tb.sv
// testbench top for the terminal line editor: stimulus, back pressure and verdict
module terminal_line_editor_tb;
    import tle_pkg::*;

    localparam int RANDOM_ITEMS    = 125;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    // unknown final byte of a control sequence
    localparam logic [7:0] BYTE_RIGHT = 8'h43;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic [7:0] in_data;
    wire        in_ready;
    wire        out_valid;
    logic       out_ready;
    wire  [7:0] out_byte;
    wire  [1:0] out_kind;
    wire        out_last;

    int fail_count;
    int pending;
    int checked;
    int lines;

    int sent_count     = 0;
    int directed_count = 0;
    // sender runs without gaps while set
    bit steady_send    = 1'b0;
    // asks the receiver for one long hold-off
    bit hold_off_req   = 1'b0;

    // 10 unit clock period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    terminal_line_editor u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),    // [7:0] rx_byte
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_byte),   // [7:0] out_byte
        .m_axis_tuser  (out_kind),   // [1:0] out_kind
        .m_axis_tlast  (out_last)
    );

    // watches both channels, predicts every result and compares
    tle_result_checker u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (in_valid),
        .i_rx_ready   (in_ready),
        .i_rx_byte    (in_data),
        .i_res_valid  (out_valid),
        .i_res_ready  (out_ready),
        .i_res_byte   (out_byte),
        .i_res_kind   (out_kind),
        .i_res_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_lines      (lines)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // any byte that the editor takes as text
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == BYTE_ESC || b == BYTE_BS || b == BYTE_DEL
                   || b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    // offer one byte, wait for its transaction, then maybe idle;
    // with no gap valid stays high into the next byte
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // esc [ final
    task automatic send_escape(input logic [7:0] final_byte);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRK);
        send_byte(final_byte);
    endtask

    // n text bytes, a backspace or delete mixed in now and then
    task automatic type_text(input int n, input bit with_erase);
        for (int i = 0; i < n; i++) begin
            if (with_erase && $urandom_range(0, 9) == 0)
                send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
            send_byte(pick_plain());
        end
    endtask

    function automatic int pick_line_len();
        // a quarter of the lines are drawn long, most of them running into the full-line limit
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(14, 18);
        return $urandom_range(0, 8);
    endfunction

    // receiver: random ready pattern, long steady stretches, one long hold-off on request
    initial begin : receiver
        int run_len;
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                // block has to fill its queue and stall the input during this
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 10);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // sender and verdict
    initial begin : stimulus
        int n;
        int k;
        int pick;
        int random_end;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty-line corner cases first
        send_byte(BYTE_BS);             // backspace on empty line, nothing emitted
        send_byte(BYTE_DEL);            // same for delete
        send_byte(BYTE_CR);             // empty line, only cr lf
        send_byte(BYTE_LF);
        send_escape(BYTE_UP);           // up with nothing stored
        send_escape(BYTE_DOWN);         // down while not browsing
        send_byte(BYTE_ESC);            // second esc is dropped and ends the escape
        send_byte(BYTE_ESC);
        send_escape(BYTE_RIGHT);        // unknown final byte dropped
        send_byte(8'h00);               // lowest and highest text bytes
        send_byte(8'hFF);
        send_byte(BYTE_DEL);            // erase one
        send_byte(BYTE_CR);             // one-byte line delivered and stored
        send_escape(BYTE_UP);           // recall newest
        send_escape(BYTE_UP);           // already at oldest, nothing
        send_escape(BYTE_DOWN);         // down from newest erases and ends browsing
        directed_count = sent_count;

        // long receiver hold-off while a full line goes in, bytes past the limit dropped
        hold_off_req = 1'b1;
        steady_send  = 1'b1;
        type_text(LINE_BYTES + 1, 1'b0);
        send_byte(BYTE_CR);
        type_text(LINE_BYTES, 1'b0);
        send_escape(BYTE_UP);           // erase a full line and echo a full one

        // random part: mostly well-formed editing with random content
        random_end = directed_count + RANDOM_ITEMS;
        while (sent_count < random_end) begin
            steady_send = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                // a line, finished by cr or lf
                type_text(pick_line_len(), 1'b1);
                send_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            end else if (pick < 14) begin
                // browse the history over a partly typed line
                n = $urandom_range(0, 1) ? 0 : pick_line_len();
                type_text(n, 1'b0);
                k = $urandom_range(1, 5);
                repeat (k)
                    send_escape(($urandom_range(0, 9) < 6) ? BYTE_UP : BYTE_DOWN);
                if ($urandom_range(0, 1))
                    send_byte(pick_plain());
                if ($urandom_range(0, 2) != 0)
                    send_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            end else if (pick < 17) begin
                // broken escape sequence
                send_byte(BYTE_ESC);
                if ($urandom_range(0, 1))
                    send_byte(BYTE_LBRK);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // raw noise
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        steady_send = 1'b0;
        in_valid <= 1'b0;

        // let the checker see the last transaction, then drain
        repeat (2) @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d received bytes, %0d of them directed, %0d results compared",
                 sent_count, directed_count, checked);
        $display("%0d finished lines delivered, with history recall, full lines and escapes",
                 lines);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            if (pending != 0)
                $display("%0d predicted results never arrived", pending);
            $display("Verification failed");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin : watchdog
        #50_000_000;
        $display("timeout: %0d bytes sent, %0d results still expected", sent_count, pending);
        $display("Verification failed");
        $finish;
    end

endmodule
